// ----- hw/rtl/hsv_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv_pkg
// Widths, payload types and sector codes shared by the HSV to RGB converter
// and its stream interfaces.
// ----------------------------------------------------------------------------
package hsv_pkg;

  // Fixed-point format: FRAC_BITS fraction bits, ONE_C means 1.0.
  localparam int FRAC_BITS = 16;
  localparam int HUE_W     = FRAC_BITS + 2;
  localparam int CH_W      = FRAC_BITS + 1;
  localparam int SECT_W    = 3;
  localparam int H6_W      = FRAC_BITS + SECT_W;

  localparam logic [CH_W-1:0] ONE_C      = CH_W'(1) << FRAC_BITS;
  localparam logic [CH_W-1:0] GREY_LIMIT = CH_W'((64'd1 << FRAC_BITS) / 64'd10000);

  typedef logic signed [HUE_W-1:0] hue_t;
  typedef logic [CH_W-1:0]         chan_t;
  typedef logic [FRAC_BITS-1:0]    frac_t;
  typedef logic [SECT_W-1:0]       sect_t;

  // Hue sectors, named by the pair of primaries/secondaries they span.
  localparam sect_t SECT_RED_YEL  = 3'd0;
  localparam sect_t SECT_YEL_GRN  = 3'd1;
  localparam sect_t SECT_GRN_CYAN = 3'd2;
  localparam sect_t SECT_CYAN_BLU = 3'd3;
  localparam sect_t SECT_BLU_MAG  = 3'd4;

endpackage

// ----- hw/rtl/hsv_stream_if.sv -----
// ----------------------------------------------------------------------------
// hsv_stream_if
// Valid/ready stream interfaces for HSV input items and RGB result items.
// ----------------------------------------------------------------------------
interface hsv_in_if;
  import hsv_pkg::*;

  logic  valid;
  logic  ready;
  hue_t  hue;
  chan_t saturation;
  chan_t brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsv_out_if;
  import hsv_pkg::*;

  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  output ready);
endinterface

// ----- hw/rtl/hsv_to_rgb_convert.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert
// Converts a hue, saturation, value item into red, green and blue, all with
// 16 fraction bits; the hue is signed and the rest is unsigned fixed point.
// The block is a three-stage pipeline that takes one item every clock while
// the output is not stalled; the clock rate is set by the multiplier stages,
// which hold three products of up to 17 by 17 bits in stage two and two in
// stage three. The last stage is the output register, and a stall at the
// output holds every full stage in place while empty stages still fill, so
// no item is lost or repeated. Saturation and value above 1.0 are clamped;
// a saturation at or below the grey threshold gives grey, equal to the value.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert (
  input logic   clk,
  input logic   rst_n,
  hsv_in_if.sink    in_if,
  hsv_out_if.source out_if
);
  import hsv_pkg::*;

  // Stage enables: a stage loads when it is empty or its contents move on.
  logic en1, en2, en3;
  logic vld1_r, vld2_r, vld3_r;

  assign en3         = !vld3_r || out_if.ready;
  assign en2         = !vld2_r || en3;
  assign en1         = !vld1_r || en2;
  assign in_if.ready = en1;

  // ---------------- Stage 1: clamp, hue reduction and sector split --------
  chan_t              s_cl, v_cl;
  logic [H6_W-1:0]    h6;
  frac_t              h_red;

  logic  grey1_r, grey1_nxt;
  sect_t sect1_r;
  frac_t f1_r;
  chan_t s1_r, v1_r;

  always_comb begin
    s_cl  = (in_if.saturation > ONE_C) ? ONE_C : in_if.saturation;
    v_cl  = (in_if.brightness > ONE_C) ? ONE_C : in_if.brightness;
    // Modulo 1.0 of a two's complement hue is just its fraction bits.
    h_red = in_if.hue[FRAC_BITS-1:0];
    h6    = (H6_W'(h_red) << 2) + (H6_W'(h_red) << 1);
    grey1_nxt = (s_cl <= GREY_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en1) begin
      vld1_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      grey1_r <= grey1_nxt;
      sect1_r <= h6[H6_W-1:FRAC_BITS];
      f1_r    <= h6[FRAC_BITS-1:0];
      s1_r    <= s_cl;
      v1_r    <= v_cl;
    end
  end

  // ---------------- Stage 2: s*f, s*(1-f) and p = v*(1-s) ----------------
  localparam int PW = 2 * CH_W;

  chan_t         omf1, oms1;
  logic [PW-1:0] sf_prod, sg_prod, p_prod;

  always_comb begin
    omf1    = ONE_C - CH_W'(f1_r);
    oms1    = ONE_C - s1_r;
    sf_prod = PW'(s1_r) * PW'(f1_r);
    sg_prod = PW'(s1_r) * PW'(omf1);
    p_prod  = PW'(v1_r) * PW'(oms1);
  end

  logic  grey2_r;
  sect_t sect2_r;
  chan_t v2_r, p2_r, sf2_r, sg2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en2) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      grey2_r <= grey1_r;
      sect2_r <= sect1_r;
      v2_r    <= v1_r;
      p2_r    <= p_prod[CH_W+FRAC_BITS-1:FRAC_BITS];
      sf2_r   <= sf_prod[CH_W+FRAC_BITS-1:FRAC_BITS];
      sg2_r   <= sg_prod[CH_W+FRAC_BITS-1:FRAC_BITS];
    end
  end

  // ---------------- Stage 3: q, t and the sector select ------------------
  logic [PW-1:0] q_prod, t_prod;
  chan_t         q3, t3;
  chan_t         red_nxt, green_nxt, blue_nxt;

  always_comb begin
    q_prod = PW'(v2_r) * PW'(ONE_C - sf2_r);
    t_prod = PW'(v2_r) * PW'(ONE_C - sg2_r);
    q3     = q_prod[CH_W+FRAC_BITS-1:FRAC_BITS];
    t3     = t_prod[CH_W+FRAC_BITS-1:FRAC_BITS];

    if (grey2_r) begin
      red_nxt   = v2_r;
      green_nxt = v2_r;
      blue_nxt  = v2_r;
    end else begin
      case (sect2_r)
        SECT_RED_YEL: begin
          red_nxt = v2_r; green_nxt = t3;   blue_nxt = p2_r;
        end
        SECT_YEL_GRN: begin
          red_nxt = q3;   green_nxt = v2_r; blue_nxt = p2_r;
        end
        SECT_GRN_CYAN: begin
          red_nxt = p2_r; green_nxt = v2_r; blue_nxt = t3;
        end
        SECT_CYAN_BLU: begin
          red_nxt = p2_r; green_nxt = q3;   blue_nxt = v2_r;
        end
        SECT_BLU_MAG: begin
          red_nxt = t3;   green_nxt = p2_r; blue_nxt = v2_r;
        end
        default: begin
          red_nxt = v2_r; green_nxt = p2_r; blue_nxt = q3;
        end
      endcase
    end
  end

  chan_t red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (en3) begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_if.valid = vld3_r;
  assign out_if.red   = red_r;
  assign out_if.green = green_r;
  assign out_if.blue  = blue_r;

endmodule

// ----- tb/sv/hsv_to_rgb_convert_test.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_convert_test
// Self-checking bench for the HSV to RGB converter. Each accepted HSV item is
// run through a local fixed-point conversion, and the RGB value it yields is
// queued. The block's results are then matched in order against that queue.
// The stimulus covers the edge values, including hue wrap, the grey
// threshold, the six sector boundaries and clamping above 1.0. Long random
// runs follow, with idle gaps on both sides, one long output stall, and
// pauses in which the pipeline drains.
// ----------------------------------------------------------------------------
module hsv_to_rgb_convert_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv_pkg::*;

  localparam int GAP_MAX        = 17;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS  = 1210;
  localparam int MAX_REPORTS    = 10;
  localparam int ONE_I          = 1 << FRAC_BITS;
  localparam chan_t ONE_CH      = chan_t'(ONE_I);
  localparam hue_t  ONE_HUE     = hue_t'(ONE_I);

  localparam longint unsigned UNITY     = 64'd1 << FRAC_BITS;
  localparam longint unsigned FRAC_MASK = UNITY - 1;
  localparam longint unsigned GREY_TH   = UNITY / 10000;

  typedef struct packed {
    hue_t  hue;
    chan_t sat;
    chan_t bri;
  } hsv_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  typedef struct packed {
    hsv_t hsv;
    rgb_t rgb;
  } pending_t;

  logic clk;
  logic rst_n;

  hsv_in_if  pix_in();
  hsv_out_if rgb_out();

  hsv_to_rgb_convert dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (pix_in),
    .out_if (rgb_out)
  );

  pending_t pending_rgb[$];
  bit       in_idle_en;
  bit       out_idle_en;
  bit       hold_off_req;
  int       error_count;
  int       pixels_sent;
  int       results_checked;
  int       idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Six-sector conversion with every product truncated to FRAC_BITS.
  function automatic rgb_t hsv_pixel_to_rgb(hue_t hue, chan_t sat, chan_t bri);
    longint unsigned s, v, h6, f, p, q, t, r, g, b;
    sect_t sector;
    rgb_t rgb;
    s = (64'(sat) > UNITY) ? UNITY : 64'(sat);
    v = (64'(bri) > UNITY) ? UNITY : 64'(bri);
    if (s <= GREY_TH) begin
      r = v;
      g = v;
      b = v;
    end else begin
      // Taking only the fraction bits wraps any hue into [0, 1.0).
      h6 = 64'(hue[FRAC_BITS-1:0]) * 6;
      sector = sect_t'(h6 >> FRAC_BITS);
      f = h6 & FRAC_MASK;
      p = (v * (UNITY - s)) >> FRAC_BITS;
      q = (v * (UNITY - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
      t = (v * (UNITY - ((s * (UNITY - f)) >> FRAC_BITS))) >> FRAC_BITS;
      case (sector)
        SECT_RED_YEL: begin
          r = v; g = t; b = p;
        end
        SECT_YEL_GRN: begin
          r = q; g = v; b = p;
        end
        SECT_GRN_CYAN: begin
          r = p; g = v; b = t;
        end
        SECT_CYAN_BLU: begin
          r = p; g = q; b = v;
        end
        SECT_BLU_MAG: begin
          r = t; g = p; b = v;
        end
        default: begin
          r = v; g = p; b = q;
        end
      endcase
    end
    rgb.red   = chan_t'(r);
    rgb.green = chan_t'(g);
    rgb.blue  = chan_t'(b);
    return rgb;
  endfunction

  function automatic hsv_t random_hsv();
    int   mode;
    hsv_t px;
    mode   = $urandom_range(0, 9);
    px.hue = hue_t'(int'($urandom_range(0, 2 * ONE_I)) - ONE_I);
    px.sat = chan_t'($urandom_range(0, ONE_I));
    px.bri = chan_t'($urandom_range(0, ONE_I));
    case (mode)
      0: begin
        // Raw bit patterns, including hues, saturations and values out of range.
        px.hue = hue_t'($urandom);
        px.sat = chan_t'($urandom);
        px.bri = chan_t'($urandom);
      end
      1: px.sat = chan_t'($urandom_range(0, int'(GREY_TH) + 1));
      2: begin
        px.sat = chan_t'(ONE_I - int'($urandom_range(0, 3)));
        px.bri = chan_t'(ONE_I - int'($urandom_range(0, 3)));
      end
      3: px.hue = hue_t'((int'($urandom_range(0, 6)) * ONE_I) / 6
                         + int'($urandom_range(0, 2)) - 1);
      default: ;
    endcase
    return px;
  endfunction

  task automatic push_pixel(input hue_t hue, input chan_t sat, input chan_t bri);
    int gap;
    gap = in_idle_en ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid      <= 1'b1;
    pix_in.hue        <= hue;
    pix_in.saturation <= sat;
    pix_in.brightness <= bri;
    do @(posedge clk); while (!pix_in.ready);
    pending_rgb.push_back('{hsv: '{hue, sat, bri}, rgb: hsv_pixel_to_rgb(hue, sat, bri)});
    pixels_sent++;
  endtask

  task automatic push_random_pixel();
    hsv_t px;
    px = random_hsv();
    push_pixel(px.hue, px.sat, px.bri);
  endtask

  // The wait loop runs its body before testing, so valid is never lowered and
  // raised again in the same step.
  task automatic wait_drained();
    pix_in.valid <= 1'b0;
    do @(posedge clk); while (pending_rgb.size() != 0);
  endtask

  task automatic test_directed_edges();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    // Sector boundaries, at full saturation and value but for the hue of 0.5.
    push_pixel(0,     ONE_CH, ONE_CH);
    push_pixel(10922, ONE_CH, ONE_CH);
    push_pixel(10923, ONE_CH, ONE_CH);
    push_pixel(21846, ONE_CH, ONE_CH);
    push_pixel(32768, 40000, 50000);
    push_pixel(43691, ONE_CH, ONE_CH);
    push_pixel(54614, ONE_CH, ONE_CH);
    push_pixel(65535, ONE_CH, ONE_CH);
    // Hue of exactly 1.0 and the negative range.
    push_pixel(ONE_HUE,  50000, 60000);
    push_pixel(-ONE_HUE, 50000, 60000);
    push_pixel(-1,     50000, 60000);
    push_pixel(-32768, 50000, 60000);
    // Either side of the grey threshold.
    push_pixel(20000, 6, 30000);
    push_pixel(20000, 7, ONE_CH);
    push_pixel(20000, 0, 0);
    // Value above 1.0 clamps, also when the result is grey.
    push_pixel(7000,  0,      131071);
    push_pixel(50000, ONE_CH, 131071);
    // Saturation above 1.0 clamps.
    push_pixel(30000, 131071, 40000);
    push_pixel(-20000, 100000, 100000);
    push_pixel(5000,  ONE_CH, 0);
    // Hues outside -1.0 .. 1.0 wrap.
    push_pixel(131071,  50000, 60000);
    push_pixel(-131072, 50000, 60000);
  endtask

  task automatic test_backpressure();
    in_idle_en   = 1'b0;
    out_idle_en  = 1'b0;
    hold_off_req = 1'b1;
    repeat (60) push_random_pixel();
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  task automatic test_drain_pauses();
    repeat (4) begin
      repeat (15) push_random_pixel();
      wait_drained();
    end
  endtask

  task automatic test_random_sweep();
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 100 == 0) begin
        in_idle_en  = ($urandom_range(0, 3) != 0);
        out_idle_en = ($urandom_range(0, 3) != 0);
      end
      push_random_pixel();
    end
  endtask

  initial begin : rgb_sink
    int gap;
    rgb_out.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        rgb_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        gap = out_idle_en ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
          rgb_out.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      rgb_out.ready <= 1'b1;
      do @(posedge clk); while (!rgb_out.valid);
    end
  end

  always @(posedge clk) begin : rgb_check
    pending_t want;
    if (rst_n && rgb_out.valid && rgb_out.ready) begin
      if (pending_rgb.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("ERROR: unexpected rgb (%0d, %0d, %0d) at %0t",
                   rgb_out.red, rgb_out.green, rgb_out.blue, $realtime);
      end else begin
        want = pending_rgb.pop_front();
        results_checked++;
        if (rgb_out.red !== want.rgb.red || rgb_out.green !== want.rgb.green ||
            rgb_out.blue !== want.rgb.blue) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("ERROR: hsv (%0d, %0d, %0d) expected rgb (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                     want.hsv.hue, want.hsv.sat, want.hsv.bri,
                     want.rgb.red, want.rgb.green, want.rgb.blue,
                     rgb_out.red, rgb_out.green, rgb_out.blue);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((pix_in.valid && pix_in.ready) || (rgb_out.valid && rgb_out.ready)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no item moved for %0d cycles, %0d results outstanding",
               idle_cycles, pending_rgb.size());
      $display("** hsv_to_rgb_convert: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    pix_in.valid      <= 1'b0;
    pix_in.hue        <= '0;
    pix_in.saturation <= '0;
    pix_in.brightness <= '0;
    in_idle_en   = 1'b1;
    out_idle_en  = 1'b1;
    hold_off_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_backpressure();
    test_drain_pauses();
    test_random_sweep();

    wait_drained();
    repeat (10) @(posedge clk);
    error_count += pending_rgb.size();

    $display("Sent %0d HSV items and checked %0d RGB results (%0d errors).",
             pixels_sent, results_checked, error_count);
    $display("Covered hue wrap, grey threshold, clamping, sector edges, idle gaps,");
    $display("a %0d-cycle output stall and drains.", HOLD_CYCLES);
    if (error_count == 0) begin
      $display("** hsv_to_rgb_convert: PASSED **");
    end else begin
      $display("** hsv_to_rgb_convert: FAILED **");
    end
    $finish;
  end

endmodule
